// ===== design/cupat_pkg.sv =====
`default_nettype none

package cupat_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam int UID_W = 40;
  localparam int DIGIT_W = 4;
  localparam int PIN_W = 4 * DIGIT_W;
  localparam int STATUS_W = 3;
  localparam int ENTRY_IDX_W = 5;
  localparam int ENTRIES_USED_W = 6;

  localparam logic OP_VERIFY = 1'b0;
  localparam logic OP_REGISTER = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DENIED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_REGISTERED = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_REGISTERED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_EXISTS = 3'd5;

  typedef struct packed {
    logic               opcode;
    logic [UID_W-1:0]   card_uid;
    logic [DIGIT_W-1:0] pin_digit_first;
    logic [DIGIT_W-1:0] pin_digit_second;
    logic [DIGIT_W-1:0] pin_digit_third;
    logic [DIGIT_W-1:0] pin_digit_fourth;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [ENTRY_IDX_W-1:0]    entry_index;
    logic [ENTRIES_USED_W-1:0] entries_used;
  } rsp_t;

  typedef struct packed {
    logic [UID_W-1:0] uid;
    logic [PIN_W-1:0] pin;
  } entry_t;

  typedef struct packed {
    logic uid_hit;
    logic pin_eq;
  } cmp_t;

endpackage

`default_nettype wire

// ===== design/cupat_table.sv =====
`default_nettype none

module cupat_table #(
  parameter int TABLE_ENTRIES = cupat_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire cupat_pkg::entry_t   wr_entry,
  input  wire logic                rd_en,
  input  wire logic [IDX_W-1:0]    rd_addr,
  input  wire cupat_pkg::entry_t   key,
  output cupat_pkg::cmp_t          cmp
);

  cupat_pkg::entry_t mem [TABLE_ENTRIES];
  cupat_pkg::entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // The registered entry is compared against the request key in the next cycle.
  assign cmp.uid_hit = (rd_q_r.uid == key.uid);
  assign cmp.pin_eq  = (rd_q_r.pin == key.pin);

endmodule

`default_nettype wire

// ===== design/card_uid_pin_access_table_unit.sv =====
`default_nettype none

// Card access table that stores up to TABLE_ENTRIES pairs of a 40-bit card UID and a
// four-digit PIN, and answers each register or verify request with one response.
// The table sits in a memory with one write and one read port, scanned one entry per
// cycle through one shared comparator. The scan stops at the first entry whose UID
// matches, or after the last stored entry when the UID is not found; a register
// request against a full table skips the scan. The block takes one request at a time
// and is ready again in the cycle in which the response appears. A finished response
// waits in an output register, and the next request can be accepted while it is still
// pending; the next response then waits until the pending one is taken.
module card_uid_pin_access_table_unit #(
  parameter int TABLE_ENTRIES = cupat_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cupat_pkg::req_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cupat_pkg::rsp_t       out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  cupat_pkg::req_t   req_r, req_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_k_r, rd_k_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  cupat_pkg::rsp_t   res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  cupat_pkg::rsp_t   out_data_r, out_data_nxt;

  logic              wr_en;
  logic              rd_en;
  logic              issue;
  logic              hit;
  cupat_pkg::entry_t key;
  cupat_pkg::cmp_t   cmp;

  assign key.uid = req_r.card_uid;
  assign key.pin = {req_r.pin_digit_first, req_r.pin_digit_second,
                    req_r.pin_digit_third, req_r.pin_digit_fourth};

  cupat_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_entry(key),
    .rd_en   (rd_en),
    .rd_addr (rd_k_r[IDX_W-1:0]),
    .key     (key),
    .cmp     (cmp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign issue = (rd_k_r < count_r);
  assign hit   = cmp_vld_r && cmp.uid_hit;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    rd_k_nxt      = rd_k_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data;
          rd_k_nxt    = '0;
          cmp_vld_nxt = 1'b0;
          if (in_data.opcode == cupat_pkg::OP_REGISTER &&
              count_r >= CNT_W'(TABLE_ENTRIES)) begin
            res_nxt.status      = cupat_pkg::STATUS_FULL;
            res_nxt.entry_index = '0;
            state_nxt           = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en       = issue;
        cmp_vld_nxt = issue;
        cmp_idx_nxt = rd_k_r[IDX_W-1:0];
        if (issue) begin
          rd_k_nxt = rd_k_r + CNT_W'(1);
        end
        if (hit) begin
          res_nxt.entry_index = cupat_pkg::ENTRY_IDX_W'(cmp_idx_r);
          if (req_r.opcode == cupat_pkg::OP_REGISTER) begin
            res_nxt.status = cupat_pkg::STATUS_EXISTS;
          end else if (cmp.pin_eq) begin
            res_nxt.status = cupat_pkg::STATUS_GRANTED;
          end else begin
            res_nxt.status = cupat_pkg::STATUS_DENIED;
          end
          state_nxt = ST_DONE;
        end else if (!issue) begin
          if (req_r.opcode == cupat_pkg::OP_REGISTER) begin
            wr_en               = 1'b1;
            count_nxt           = count_r + CNT_W'(1);
            res_nxt.status      = cupat_pkg::STATUS_REGISTERED;
            res_nxt.entry_index = cupat_pkg::ENTRY_IDX_W'(count_r);
          end else begin
            res_nxt.status      = cupat_pkg::STATUS_NOT_REGISTERED;
            res_nxt.entry_index = '0;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status       = res_r.status;
          out_data_nxt.entry_index  = res_r.entry_index;
          out_data_nxt.entries_used = cupat_pkg::ENTRIES_USED_W'(count_r);
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_k_r     <= rd_k_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== dv/access_table_monitor.sv =====
`timescale 1ns / 1ps

module access_table_monitor (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  cupat_pkg::req_t  in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  cupat_pkg::rsp_t  out_data,
  output int               mismatches,
  output int               outstanding
);

  logic [cupat_pkg::UID_W-1:0] card_ids [cupat_pkg::TABLE_ENTRIES_DEF];
  logic [cupat_pkg::PIN_W-1:0] card_pins[cupat_pkg::TABLE_ENTRIES_DEF];
  int                          stored;
  cupat_pkg::rsp_t             expected_rsp[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    stored      = 0;
  end

  function automatic cupat_pkg::rsp_t decide_access(cupat_pkg::req_t r);
    cupat_pkg::rsp_t             a;
    logic [cupat_pkg::PIN_W-1:0] pin;
    int                          hit;
    pin = {r.pin_digit_first, r.pin_digit_second,
           r.pin_digit_third, r.pin_digit_fourth};
    hit = -1;
    for (int k = 0; k < stored; k++) begin
      if (hit < 0 && card_ids[k] == r.card_uid) hit = k;
    end
    a.entry_index = '0;
    if (r.opcode == cupat_pkg::OP_REGISTER) begin
      if (stored >= cupat_pkg::TABLE_ENTRIES_DEF) begin
        a.status = cupat_pkg::STATUS_FULL;
      end else if (hit >= 0) begin
        a.status      = cupat_pkg::STATUS_EXISTS;
        a.entry_index = cupat_pkg::ENTRY_IDX_W'(hit);
      end else begin
        card_ids[stored]  = r.card_uid;
        card_pins[stored] = pin;
        a.status          = cupat_pkg::STATUS_REGISTERED;
        a.entry_index     = cupat_pkg::ENTRY_IDX_W'(stored);
        stored++;
      end
    end else if (hit < 0) begin
      a.status = cupat_pkg::STATUS_NOT_REGISTERED;
    end else begin
      a.entry_index = cupat_pkg::ENTRY_IDX_W'(hit);
      a.status      = (card_pins[hit] == pin) ? cupat_pkg::STATUS_GRANTED
                                              : cupat_pkg::STATUS_DENIED;
    end
    a.entries_used = cupat_pkg::ENTRIES_USED_W'(stored);
    return a;
  endfunction

  always @(posedge clk) begin
    cupat_pkg::rsp_t e;
    if (!rst_n) begin
      stored = 0;
      expected_rsp.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with none expected: status %0d entry_index %0d",
                     $realtime, out_data.status, out_data.entry_index,
                     " entries_used %0d", out_data.entries_used);
        end else begin
          e = expected_rsp.pop_front();
          if (out_data.status !== e.status || out_data.entry_index !== e.entry_index ||
              out_data.entries_used !== e.entries_used) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: status exp %0d got %0d,", $realtime,
                       e.status, out_data.status,
                       " entry_index exp %0d got %0d,",
                       e.entry_index, out_data.entry_index,
                       " entries_used exp %0d got %0d",
                       e.entries_used, out_data.entries_used);
          end
        end
      end
      if (in_valid && in_ready) expected_rsp.push_back(decide_access(in_data));
    end
    outstanding = expected_rsp.size();
  end

endmodule

// ===== dv/card_uid_pin_access_table_unit_tb.sv =====
`timescale 1ns / 1ps

module card_uid_pin_access_table_unit_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1900;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            out_ready = 1'b0;
  cupat_pkg::req_t in_data   = '0;
  logic            in_ready;
  logic            out_valid;
  cupat_pkg::rsp_t out_data;
  int              mismatches;
  int              outstanding;
  bit              calm = 1'b0;
  int              stall_left = 0;

  logic [cupat_pkg::UID_W-1:0] known_ids[$];
  logic [cupat_pkg::PIN_W-1:0] known_pins[$];

  card_uid_pin_access_table_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  access_table_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [cupat_pkg::DIGIT_W-1:0] rand_digit();
    if ($urandom_range(0, 3) == 0) return cupat_pkg::DIGIT_W'($urandom_range(0, 15));
    return cupat_pkg::DIGIT_W'($urandom_range(0, 9));
  endfunction

  always @(posedge clk) begin
    logic nxt;
    int   n;
    if (!rst_n) begin
      nxt        = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b0;
    end else begin
      nxt = 1'b1;
      if (out_valid && out_ready) begin
        n = idle_cycles();
        if (n > 0) begin
          nxt        = 1'b0;
          stall_left = n - 1;
        end
      end
    end
    out_ready <= nxt;
  end

  task automatic issue(input logic op, input logic [cupat_pkg::UID_W-1:0] uid,
                       input logic [cupat_pkg::PIN_W-1:0] pin);
    int              n;
    bit              seen;
    cupat_pkg::req_t r;
    r.opcode   = op;
    r.card_uid = uid;
    {r.pin_digit_first, r.pin_digit_second, r.pin_digit_third, r.pin_digit_fourth} = pin;
    n = idle_cycles();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    if (op == cupat_pkg::OP_REGISTER && known_ids.size() < cupat_pkg::TABLE_ENTRIES_DEF) begin
      seen = 1'b0;
      foreach (known_ids[k]) if (known_ids[k] == uid) seen = 1'b1;
      if (!seen) begin
        known_ids.push_back(uid);
        known_pins.push_back(pin);
      end
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int                          kind;
    int                          pick;
    logic [cupat_pkg::UID_W-1:0] u;
    logic [cupat_pkg::PIN_W-1:0] p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, raw digits above nine, duplicates and near misses.
    issue(cupat_pkg::OP_VERIFY,   40'h00_0000_0000, 16'h0000);
    issue(cupat_pkg::OP_REGISTER, 40'h00_0000_0000, 16'h0000);
    issue(cupat_pkg::OP_REGISTER, 40'hFF_FFFF_FFFF, 16'hFFFF);
    issue(cupat_pkg::OP_VERIFY,   40'h00_0000_0000, 16'h0000);
    issue(cupat_pkg::OP_VERIFY,   40'hFF_FFFF_FFFF, 16'hFFFF);
    issue(cupat_pkg::OP_VERIFY,   40'hFF_FFFF_FFFF, 16'hFFFE);
    issue(cupat_pkg::OP_VERIFY,   40'hFF_FFFF_FFFF, 16'h9999);
    issue(cupat_pkg::OP_REGISTER, 40'h00_0000_0000, 16'h1234);
    issue(cupat_pkg::OP_VERIFY,   40'h00_0000_0000, 16'h1234);
    issue(cupat_pkg::OP_REGISTER, 40'h80_0000_0000, 16'h9090);
    issue(cupat_pkg::OP_VERIFY,   40'h00_0000_0001, 16'h9090);
    issue(cupat_pkg::OP_VERIFY,   40'h80_0000_0000, 16'h9090);
    issue(cupat_pkg::OP_VERIFY,   40'h80_0000_0000, 16'h0909);
    issue(cupat_pkg::OP_REGISTER, 40'hFF_FFFF_FFFF, 16'h0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 149) == 0) calm = !calm;
      kind = $urandom_range(0, 99);
      pick = (known_ids.size() > 0) ? $urandom_range(0, known_ids.size() - 1) : 0;
      u    = cupat_pkg::UID_W'({$urandom(), $urandom()});
      p    = {rand_digit(), rand_digit(), rand_digit(), rand_digit()};
      if (known_ids.size() == 0 || (kind >= 60 && kind < 70))
        issue(cupat_pkg::OP_VERIFY, u, p);
      else if (kind < 40)
        issue(cupat_pkg::OP_VERIFY, known_ids[pick], known_pins[pick]);
      else if (kind < 55)
        issue(cupat_pkg::OP_VERIFY, known_ids[pick],
              known_pins[pick] ^ (16'h1 << $urandom_range(0, 15)));
      else if (kind < 60)
        issue(cupat_pkg::OP_VERIFY, known_ids[pick] ^ (40'h1 << $urandom_range(0, 39)),
              known_pins[pick]);
      else if (kind < 85)
        issue(cupat_pkg::OP_REGISTER, u, p);
      else
        issue(cupat_pkg::OP_REGISTER, known_ids[pick], p);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
